### design/cre_pkg.sv
`timescale 1ns / 1ps

package cre_pkg;

    // Width of one credential id.
    localparam int unsigned IdWidth = 32;

    // An id of all ones asks for the current value to be kept; set-id refuses it as invalid.
    localparam logic [IdWidth-1:0] ID_HOLD = {IdWidth{1'b1}};

    // Operation codes carried in the func field of a request.
    localparam logic [2:0] FUNC_SET_ID  = 3'd0;
    localparam logic [2:0] FUNC_SET_RE  = 3'd1;
    localparam logic [2:0] FUNC_SET_RES = 3'd2;
    localparam logic [2:0] FUNC_SET_FS  = 3'd3;
    localparam logic [2:0] FUNC_READ    = 3'd4;

    // Family select codes.
    localparam logic FAMILY_USER  = 1'b0;
    localparam logic FAMILY_GROUP = 1'b1;

    typedef logic [IdWidth-1:0] id_t;

    // Completion status of a request.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_PERM  = 2'd2
    } status_t;

    // One credential quad.
    typedef struct packed {
        id_t real_id;
        id_t effective_id;
        id_t saved_id;
        id_t fs_id;
    } quad_t;

endpackage

### design/cre_if.sv
`timescale 1ns / 1ps

// Request channel.
interface cre_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic        family;
    logic [31:0] first_id;
    logic [31:0] second_id;
    logic [31:0] third_id;

    modport source (output valid, output func, output family, output first_id,
                    output second_id, output third_id, input ready);
    modport sink   (input valid, input func, input family, input first_id,
                    input second_id, input third_id, output ready);
endinterface

// Result channel.
interface cre_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] prior_fs_id;
    logic [31:0] real_out;
    logic [31:0] effective_out;
    logic [31:0] saved_out;
    logic [31:0] fs_out;

    modport source (output valid, output status, output prior_fs_id, output real_out,
                    output effective_out, output saved_out, output fs_out,
                    input ready);
    modport sink   (input valid, input status, input prior_fs_id, input real_out,
                    input effective_out, input saved_out, input fs_out,
                    output ready);
endinterface

### design/cre_state.sv
`timescale 1ns / 1ps

module cre_state (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic          family,
    input  cre_pkg::quad_t new_q,
    output cre_pkg::quad_t sel_q,
    output logic          priv
);
    import cre_pkg::*;

    quad_t user_q_reg;
    quad_t user_q_next;
    quad_t group_q_reg;
    quad_t group_q_next;

    // Only the selected family is written; a refused request writes back
    // the old values.
    always_comb
    begin
        user_q_next  = user_q_reg;
        group_q_next = group_q_reg;
        if (we)
        begin
            if (family == FAMILY_GROUP)
            begin
                group_q_next = new_q;
            end
            else
            begin
                user_q_next = new_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_q_reg  <= '0;
            group_q_reg <= '0;
        end
        else
        begin
            user_q_reg  <= user_q_next;
            group_q_reg <= group_q_next;
        end
    end

    // Selected quad and the privilege test, which looks at the user
    // effective id for both families.
    assign sel_q = (family == FAMILY_GROUP) ? group_q_reg : user_q_reg;
    assign priv  = (user_q_reg.effective_id == '0);

endmodule

### design/cre_rules.sv
`timescale 1ns / 1ps

module cre_rules (
    input  logic           [2:0] func,
    input  cre_pkg::id_t         first_id,
    input  cre_pkg::id_t         second_id,
    input  cre_pkg::id_t         third_id,
    input  cre_pkg::quad_t       cur_q,
    input  logic                 priv,
    output cre_pkg::status_t     status,
    output cre_pkg::quad_t       next_q
);
    import cre_pkg::*;

    logic a_keep;
    logic b_keep;
    logic c_keep;
    logic a_in_re;
    logic a_in_rs;
    logic a_in_res;
    logic b_in_re;
    logic b_in_res;
    logic c_in_res;
    logic a_in_all;

    // Membership tests against the current quad.
    always_comb
    begin
        a_keep   = (first_id == ID_HOLD);
        b_keep   = (second_id == ID_HOLD);
        c_keep   = (third_id == ID_HOLD);
        a_in_re  = (first_id == cur_q.real_id) || (first_id == cur_q.effective_id);
        a_in_rs  = (first_id == cur_q.real_id) || (first_id == cur_q.saved_id);
        a_in_res = a_in_re || (first_id == cur_q.saved_id);
        a_in_all = a_in_res || (first_id == cur_q.fs_id);
        b_in_re  = (second_id == cur_q.real_id) || (second_id == cur_q.effective_id);
        b_in_res = b_in_re || (second_id == cur_q.saved_id);
        c_in_res = (third_id == cur_q.real_id) || (third_id == cur_q.effective_id)
                   || (third_id == cur_q.saved_id);
    end

    // Permission checks and the new quad; a refused request keeps the quad.
    always_comb
    begin
        status = ST_OK;
        next_q = cur_q;
        case (func)
            FUNC_SET_ID:
            begin
                if (a_keep)
                begin
                    status = ST_INVAL;
                end
                else if (priv)
                begin
                    next_q.real_id      = first_id;
                    next_q.effective_id = first_id;
                    next_q.saved_id     = first_id;
                    next_q.fs_id        = first_id;
                end
                else if (a_in_rs)
                begin
                    next_q.effective_id = first_id;
                    next_q.fs_id        = first_id;
                end
                else
                begin
                    status = ST_PERM;
                end
            end
            FUNC_SET_RE:
            begin
                if ((!a_keep && !(priv || a_in_re)) || (!b_keep && !(priv || b_in_res)))
                begin
                    status = ST_PERM;
                end
                else
                begin
                    if (!a_keep)
                    begin
                        next_q.real_id = first_id;
                    end
                    if (!b_keep)
                    begin
                        next_q.effective_id = second_id;
                    end
                    // The saved id follows the new effective id when the real
                    // id is set or the effective id moves away from the real.
                    if (!a_keep || (!b_keep && (second_id != cur_q.real_id)))
                    begin
                        next_q.saved_id = next_q.effective_id;
                    end
                    next_q.fs_id = next_q.effective_id;
                end
            end
            FUNC_SET_RES:
            begin
                if (!priv && ((!a_keep && !a_in_res) || (!b_keep && !b_in_res)
                              || (!c_keep && !c_in_res)))
                begin
                    status = ST_PERM;
                end
                else
                begin
                    if (!a_keep)
                    begin
                        next_q.real_id = first_id;
                    end
                    if (!b_keep)
                    begin
                        next_q.effective_id = second_id;
                    end
                    if (!c_keep)
                    begin
                        next_q.saved_id = third_id;
                    end
                    next_q.fs_id = next_q.effective_id;
                end
            end
            FUNC_SET_FS:
            begin
                // Never reports an error; an id that is not allowed is ignored.
                if (!a_keep && (priv || a_in_all))
                begin
                    next_q.fs_id = first_id;
                end
            end
            FUNC_READ:
            begin
                status = ST_OK;
            end
            default:
            begin
                status = ST_INVAL;
            end
        endcase
    end

endmodule

### design/credential_id_rule_engine.sv
`timescale 1ns / 1ps

// Credential id rule engine. The block holds a user and a group credential
// quad (real, effective, saved and filesystem id) and applies the set-id
// permission and saved-id rules to the quad that each request selects; a
// refused request changes nothing. Every request gives exactly one result
// with the status, the filesystem id before the request and the quad after
// it. A request is registered on entry, the rules are evaluated against the
// credential registers, and the result is registered. One request is accepted
// in every cycle while results are taken; the rate is one request per cycle,
// set by the single read-modify-write of the credential registers. After
// reset both quads are zero, so the caller starts privileged.
module credential_id_rule_engine (
    input  logic clk,
    input  logic rst_n,
    cre_req_if.sink   req,
    cre_rsp_if.source rsp
);
    import cre_pkg::*;

    // Input register.
    logic       s1_valid_reg;
    logic [2:0] s1_func_reg;
    logic       s1_family_reg;
    id_t        s1_first_reg;
    id_t        s1_second_reg;
    id_t        s1_third_reg;

    // Result register.
    logic       out_valid_reg;
    status_t    out_status_reg;
    id_t        out_prior_fs_reg;
    quad_t      out_q_reg;

    logic       advance;
    logic       take_req;
    quad_t      sel_q;
    quad_t      next_q;
    logic       priv;
    status_t    status;

    // The input stage moves on when the result register is empty or is
    // being emptied in this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign take_req = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            s1_func_reg   <= req.func;
            s1_family_reg <= req.family;
            s1_first_reg  <= req.first_id;
            s1_second_reg <= req.second_id;
            s1_third_reg  <= req.third_id;
        end
    end

    // Credential registers.
    cre_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (advance),
        .family (s1_family_reg),
        .new_q  (next_q),
        .sel_q  (sel_q),
        .priv   (priv)
    );

    // Permission and saved-id rules.
    cre_rules u_rules (
        .func      (s1_func_reg),
        .first_id  (s1_first_reg),
        .second_id (s1_second_reg),
        .third_id  (s1_third_reg),
        .cur_q     (sel_q),
        .priv      (priv),
        .status    (status),
        .next_q    (next_q)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg   <= status;
            out_prior_fs_reg <= sel_q.fs_id;
            out_q_reg        <= next_q;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.prior_fs_id   = out_prior_fs_reg;
    assign rsp.real_out      = out_q_reg.real_id;
    assign rsp.effective_out = out_q_reg.effective_id;
    assign rsp.saved_out     = out_q_reg.saved_id;
    assign rsp.fs_out        = out_q_reg.fs_id;

    // A failed request leaves the filesystem id as it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.prior_fs_id == rsp.fs_out))
        else $error("failed request changed the filesystem id");

    // A held input stage behind a stalled result must block new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request accepted while the pipeline is stalled");

    // Every successful set of the effective id also sets the filesystem id.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (status == ST_OK) && ((s1_func_reg == FUNC_SET_ID)
            || (s1_func_reg == FUNC_SET_RE) || (s1_func_reg == FUNC_SET_RES)))
        |=> (rsp.fs_out == rsp.effective_out))
        else $error("filesystem id does not follow the effective id");

    // A read changes neither the quad nor reports an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_func_reg == FUNC_READ))
        |=> ((rsp.status == ST_OK) && (rsp.fs_out == rsp.prior_fs_id)))
        else $error("read request altered state");

endmodule

### tb/credential_id_rule_engine_tb.sv
`timescale 1ns / 1ps

module credential_id_rule_engine_tb;

    import cre_pkg::*;

    localparam int          IDLE_PCT      = 24;
    localparam int          RANDOM_ITEMS  = 1625;
    localparam int          MAX_TRIES     = 20;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          QUIET_FIRST   = 700;
    localparam int          QUIET_LAST    = 1000;
    localparam longint      TIMEOUT_NS    = 1_000_000;
    localparam logic [2:0]  FUNC_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  FUNC_RSVD_MID   = 3'd6;
    localparam logic [2:0]  FUNC_RSVD_LAST  = 3'd7;

    // Both credential quads as the block should hold them.
    typedef struct packed {
        quad_t user_q;
        quad_t group_q;
    } cred_state_t;

    typedef struct packed {
        logic [2:0] func;
        logic       family;
        id_t        first_id;
        id_t        second_id;
        id_t        third_id;
    } cred_req_t;

    typedef struct packed {
        status_t status;
        id_t     prior_fs;
        quad_t   quad;
    } cred_rsp_t;

    logic clk;
    logic rst_n;

    cre_req_if req_if ();
    cre_rsp_if rsp_if ();

    credential_id_rule_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    cred_req_t   pending_reqs[$];
    cred_rsp_t   expected_rsps[$];
    cred_state_t plan_state;
    cred_state_t dut_creds;
    logic        req_fire;
    int          sent_count;
    int          accepted_count;
    int          total_count;
    int          mismatch_count;
    int          granted_count;
    int          invalid_count;
    int          refused_count;
    int          privileged_count;

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies the set-id rules to the selected quad; a refused request leaves
    // the state untouched. The caller is privileged when the user effective
    // id is zero, whichever family is selected.
    function automatic cred_rsp_t apply_cred_rules(inout cred_state_t creds,
                                                   input cred_req_t rq);
        quad_t     q0;
        quad_t     q;
        logic      priv;
        status_t   stat;
        id_t       a;
        id_t       b;
        id_t       c;
        cred_rsp_t res;
        q0   = (rq.family == FAMILY_GROUP) ? creds.group_q : creds.user_q;
        q    = q0;
        priv = (creds.user_q.effective_id == '0);
        stat = ST_OK;
        a    = rq.first_id;
        b    = rq.second_id;
        c    = rq.third_id;
        case (rq.func)
            FUNC_SET_ID:
            begin
                if (a == ID_HOLD)
                begin
                    stat = ST_INVAL;
                end
                else if (priv)
                begin
                    q = '{a, a, a, a};
                end
                else if (a == q0.real_id || a == q0.saved_id)
                begin
                    q.effective_id = a;
                    q.fs_id        = a;
                end
                else
                begin
                    stat = ST_PERM;
                end
            end
            FUNC_SET_RE:
            begin
                if (a != ID_HOLD && !(priv || a == q0.real_id || a == q0.effective_id))
                    stat = ST_PERM;
                if (b != ID_HOLD && !(priv || b == q0.real_id || b == q0.effective_id
                                      || b == q0.saved_id))
                    stat = ST_PERM;
                if (stat == ST_OK)
                begin
                    if (a != ID_HOLD)
                        q.real_id = a;
                    if (b != ID_HOLD)
                        q.effective_id = b;
                    // The saved id follows a new real id, or an effective id
                    // that moves away from the old real id.
                    if (a != ID_HOLD || (b != ID_HOLD && b != q0.real_id))
                        q.saved_id = q.effective_id;
                    q.fs_id = q.effective_id;
                end
            end
            FUNC_SET_RES:
            begin
                if (!priv)
                begin
                    if (a != ID_HOLD && a != q0.real_id && a != q0.effective_id
                        && a != q0.saved_id)
                        stat = ST_PERM;
                    if (b != ID_HOLD && b != q0.real_id && b != q0.effective_id
                        && b != q0.saved_id)
                        stat = ST_PERM;
                    if (c != ID_HOLD && c != q0.real_id && c != q0.effective_id
                        && c != q0.saved_id)
                        stat = ST_PERM;
                end
                if (stat == ST_OK)
                begin
                    if (a != ID_HOLD)
                        q.real_id = a;
                    if (b != ID_HOLD)
                        q.effective_id = b;
                    if (c != ID_HOLD)
                        q.saved_id = c;
                    q.fs_id = q.effective_id;
                end
            end
            FUNC_SET_FS:
            begin
                // A filesystem id that is not allowed is silently ignored.
                if (a != ID_HOLD && (priv || a == q0.real_id || a == q0.effective_id
                                     || a == q0.saved_id || a == q0.fs_id))
                    q.fs_id = a;
            end
            FUNC_READ:
            begin
            end
            default:
            begin
                stat = ST_INVAL;
            end
        endcase
        if (rq.family == FAMILY_GROUP)
            creds.group_q = q;
        else
            creds.user_q = q;
        res.status   = stat;
        res.prior_fs = q0.fs_id;
        res.quad     = q;
        return res;
    endfunction

    // The caller can only regain privilege while a user id of zero remains.
    function automatic logic user_has_zero(cred_state_t creds);
        return creds.user_q.real_id == '0 || creds.user_q.effective_id == '0
            || creds.user_q.saved_id == '0;
    endfunction

    // Ids are mostly drawn from the selected quad and a small pool, so that
    // the equality rules are met often; the rest are keep values and
    // arbitrary ids.
    function automatic id_t pick_id(quad_t q);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return ID_HOLD;
        if (roll < 30)
            return $urandom;
        if (roll < 65)
        begin
            case ($urandom_range(0, 3))
                0:       return q.real_id;
                1:       return q.effective_id;
                2:       return q.saved_id;
                default: return q.fs_id;
            endcase
        end
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd2;
            3:       return 32'd3;
            default: return ID_HOLD - 1;
        endcase
    endfunction

    // Queues one request and advances the planning copy of the credentials.
    task automatic add_req(logic [2:0] func, logic family, id_t a, id_t b, id_t c);
        cred_req_t rq;
        rq = '{func, family, a, b, c};
        void'(apply_cred_rules(plan_state, rq));
        pending_reqs.push_back(rq);
    endtask

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic logic quiet_stretch();
        return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
    endfunction

    // Request driver and result back-pressure, both on the falling edge.
    always @(negedge clk)
    begin : drive_requests
        cred_req_t nxt;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= quiet_stretch() || ($urandom_range(0, 99) >= IDLE_PCT);
            if (!req_if.valid || req_fire)
            begin
                if (pending_reqs.size() != 0
                    && (quiet_stretch() || ($urandom_range(0, 99) >= IDLE_PCT)))
                begin
                    nxt = pending_reqs.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.func      <= nxt.func;
                    req_if.family    <= nxt.family;
                    req_if.first_id  <= nxt.first_id;
                    req_if.second_id <= nxt.second_id;
                    req_if.third_id  <= nxt.third_id;
                    sent_count++;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts each accepted request and checks each result.
    always @(posedge clk)
    begin : watch_channels
        cred_req_t acc;
        cred_rsp_t want;
        cred_rsp_t got;
        if (!rst_n)
        begin
            req_fire <= 1'b0;
        end
        else
        begin
            req_fire <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready)
            begin
                acc = '{req_if.func, req_if.family, req_if.first_id,
                        req_if.second_id, req_if.third_id};
                if (dut_creds.user_q.effective_id == '0)
                    privileged_count++;
                want = apply_cred_rules(dut_creds, acc);
                expected_rsps.push_back(want);
                accepted_count++;
                case (want.status)
                    ST_OK:    granted_count++;
                    ST_INVAL: invalid_count++;
                    default:  refused_count++;
                endcase
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.status             = status_t'(rsp_if.status);
                got.prior_fs           = rsp_if.prior_fs_id;
                got.quad.real_id       = rsp_if.real_out;
                got.quad.effective_id  = rsp_if.effective_out;
                got.quad.saved_id      = rsp_if.saved_out;
                got.quad.fs_id         = rsp_if.fs_out;
                if (expected_rsps.size() == 0)
                begin
                    note_mismatch($sformatf("result with no request outstanding: st=%0d",
                                            got.status));
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got !== want)
                        note_mismatch($sformatf({"st %0d/%0d prior %h/%h real %h/%h ",
                                                 "eff %h/%h saved %h/%h fs %h/%h"},
                                                want.status, got.status,
                                                want.prior_fs, got.prior_fs,
                                                want.quad.real_id, got.quad.real_id,
                                                want.quad.effective_id,
                                                got.quad.effective_id,
                                                want.quad.saved_id, got.quad.saved_id,
                                                want.quad.fs_id, got.quad.fs_id));
                end
            end
        end
    end

    // Stimulus, end of run and verdict.
    initial
    begin : stimulus
        cred_req_t   cand;
        cred_state_t trial;
        quad_t       sel;
        int          tries;
        logic        keeps;
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.func      = FUNC_READ;
        req_if.family    = FAMILY_USER;
        req_if.first_id  = '0;
        req_if.second_id = '0;
        req_if.third_id  = '0;
        rsp_if.ready     = 1'b0;
        req_fire         = 1'b0;
        plan_state       = '0;
        dut_creds        = '0;
        sent_count       = 0;
        accepted_count   = 0;
        mismatch_count   = 0;
        granted_count    = 0;
        invalid_count    = 0;
        refused_count    = 0;
        privileged_count = 0;

        // Directed part: keep values, unused codes, privileged and
        // unprivileged forms of each operation, and refused requests.
        add_req(FUNC_READ,       FAMILY_USER,  '0, '0, '0);
        add_req(FUNC_SET_ID,     FAMILY_USER,  ID_HOLD, '0, '0);
        add_req(FUNC_SET_FS,     FAMILY_USER,  ID_HOLD, '0, '0);
        add_req(FUNC_RSVD_FIRST, FAMILY_USER,  32'd1, 32'd1, 32'd1);
        add_req(FUNC_RSVD_MID,   FAMILY_GROUP, ID_HOLD, ID_HOLD, ID_HOLD);
        add_req(FUNC_RSVD_LAST,  FAMILY_GROUP, '0, '0, '0);
        add_req(FUNC_SET_ID,     FAMILY_GROUP, ID_HOLD - 1, '0, '0);
        add_req(FUNC_SET_RES,    FAMILY_GROUP, ID_HOLD, ID_HOLD, ID_HOLD);
        add_req(FUNC_SET_RE,     FAMILY_GROUP, 32'd5, 32'd7, '0);
        add_req(FUNC_SET_RES,    FAMILY_USER,  32'd1, 32'd2, 32'd0);
        add_req(FUNC_SET_ID,     FAMILY_USER,  32'd3, '0, '0);
        add_req(FUNC_SET_ID,     FAMILY_USER,  32'd1, '0, '0);
        add_req(FUNC_SET_FS,     FAMILY_USER,  32'd9, '0, '0);
        add_req(FUNC_SET_FS,     FAMILY_USER,  32'd0, '0, '0);
        add_req(FUNC_SET_RE,     FAMILY_USER,  32'd2, ID_HOLD, '0);
        add_req(FUNC_SET_RE,     FAMILY_USER,  ID_HOLD, 32'd0, '0);
        add_req(FUNC_SET_RES,    FAMILY_GROUP, 32'd0, ID_HOLD - 1, 32'd3);
        add_req(FUNC_SET_ID,     FAMILY_USER,  32'd0, '0, '0);
        add_req(FUNC_SET_RE,     FAMILY_USER,  32'd7, ID_HOLD, '0);
        add_req(FUNC_SET_RES,    FAMILY_USER,  ID_HOLD, 32'd7, ID_HOLD);
        add_req(FUNC_SET_RES,    FAMILY_GROUP, 32'd3, 32'd9, ID_HOLD);
        add_req(FUNC_SET_ID,     FAMILY_GROUP, 32'd3, '0, '0);
        add_req(FUNC_READ,       FAMILY_GROUP, ID_HOLD, ID_HOLD, ID_HOLD);
        add_req(FUNC_SET_RES,    FAMILY_USER,  32'd0, 32'd0, 32'd0);

        // Random part. Until late in the run, a request that would leave no
        // user id of zero is drawn again, so that privilege can still return.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            tries = 0;
            do
            begin
                if ($urandom_range(0, 99) < 5)
                    cand.func = 3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
                else
                    cand.func = 3'($urandom_range(FUNC_SET_ID, FUNC_READ));
                cand.family = ($urandom_range(0, 1) == 0) ? FAMILY_USER : FAMILY_GROUP;
                sel = (cand.family == FAMILY_GROUP) ? plan_state.group_q
                                                    : plan_state.user_q;
                cand.first_id  = pick_id(sel);
                cand.second_id = pick_id(sel);
                cand.third_id  = pick_id(sel);
                trial = plan_state;
                void'(apply_cred_rules(trial, cand));
                tries++;
                keeps = !user_has_zero(plan_state) || user_has_zero(trial)
                        || n >= (RANDOM_ITEMS * 9) / 10;
            end
            while (!keeps && tries < MAX_TRIES);
            if (!keeps)
                cand.func = FUNC_READ;
            add_req(cand.func, cand.family, cand.first_id, cand.second_id, cand.third_id);
        end
        total_count = pending_reqs.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_count || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_rsps.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));

        $display("Ran %0d requests: %0d granted, %0d invalid, %0d refused.",
                 accepted_count, granted_count, invalid_count, refused_count);
        $display("%0d requests were made by a privileged caller; %0d mismatches.",
                 privileged_count, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d of %0d requests accepted.", accepted_count, total_count);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
design/cre_pkg.sv
design/cre_if.sv
design/cre_state.sv
design/cre_rules.sv
design/credential_id_rule_engine.sv
tb/credential_id_rule_engine_tb.sv
